@@ rtl/srgt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package srgt_pkg;

    // Field widths fixed by the interface
    localparam int unsigned CFG_W    = 9;
    localparam int unsigned SID_W    = 16;
    localparam int unsigned EPOCH_W  = 32;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned ID_W     = 8;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned REJ_W    = 32;

    localparam logic [CFG_W-1:0] MAX_SESSIONS_RST = 9'd256;

    // Command codes
    localparam logic [1:0] CMD_OPEN      = 2'd0;
    localparam logic [1:0] CMD_CLOSE     = 2'd1;
    localparam logic [1:0] CMD_AUTH      = 2'd2;
    localparam logic [1:0] CMD_CLOSE_ALL = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNAUTHORIZED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLOSED       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_STALE        = 3'd5;
    localparam logic [STATUS_W-1:0] ST_REPLAY       = 3'd6;

    // Controls from the sequencer to the entry store
    typedef struct packed {
        logic rd_en;
        logic epoch_we;
        logic closed_we;
        logic seq_we;
        logic closed_wdata;
    } t_store_ctl;

endpackage

`default_nettype wire

@@ rtl/session_replay_guard_table.sv @@
// Open and close return their result from S_DECODE through the registered done strobe;
// authorise answers an unknown id from S_DECODE, else runs one check per cycle
// from S_CHK_DIG to S_CHK_SEQ; close all reads each entry, writing those still open.
// The next transaction is taken in the strobe cycle (busy low); results never stall.
// Synchronous active-low reset clears the session count, the rejection counter and
// sets the session limit to 256; table entries need no clearing, each is written at open.
`timescale 1ns / 1ps
`default_nettype none

module session_replay_guard_table
    import srgt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_command,
    input  wire logic [SID_W-1:0]    i_session_id,
    input  wire logic [EPOCH_W-1:0]  i_request_epoch,
    input  wire logic                i_credentials_valid,
    input  wire logic [EPOCH_W-1:0]  i_current_epoch,
    input  wire logic [WORD_W-1:0]   i_request_boot_digest,
    input  wire logic [WORD_W-1:0]   i_current_boot_digest,
    input  wire logic [WORD_W-1:0]   i_request_seq,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    output logic                     o_done,
    output logic [STATUS_W-1:0]      o_status,
    output logic [ID_W-1:0]          o_assigned_id,
    output logic [COUNT_W-1:0]       o_closed_count,
    output logic [COUNT_W-1:0]       o_open_count,
    output logic [REJ_W-1:0]         o_rejection_count
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DECODE    = 9'b000000010,
        S_CHK_DIG   = 9'b000000100,
        S_CHK_REQEP = 9'b000001000,
        S_CHK_ENTEP = 9'b000010000,
        S_CHK_BOOT  = 9'b000100000,
        S_CHK_SEQ   = 9'b001000000,
        S_WALK_RD   = 9'b010000000,
        S_WALK_WR   = 9'b100000000
    } t_state;

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_max, n_max;
    logic [CNT_W-1:0]     r_total, n_total;
    logic [REJ_W-1:0]     r_rej, n_rej;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]     r_ccnt, n_ccnt;
    logic                 r_done, n_done;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [ID_W-1:0]      r_assigned, n_assigned;

    // Captured transaction
    logic [1:0]           r_cmd;
    logic [SID_W-1:0]     r_sid;
    logic [EPOCH_W-1:0]   r_req_epoch;
    logic                 r_creds;
    logic [EPOCH_W-1:0]   r_cur_epoch;
    logic [WORD_W-1:0]    r_req_dig;
    logic [WORD_W-1:0]    r_cur_dig;
    logic [WORD_W-1:0]    r_req_seq;

    t_store_ctl           mem_ctl;
    logic [IDX_W-1:0]     mem_addr;
    logic [WORD_W-1:0]    mem_wr_seq;
    logic [EPOCH_W-1:0]   rd_epoch;
    logic                 rd_closed;
    logic [WORD_W-1:0]    rd_seq;

    logic [WORD_W-1:0]    cmp_a, cmp_b;
    logic                 cmp_eq, cmp_le;

    logic                 accept;
    logic                 sid_known;
    logic                 table_full;
    logic                 walk_last;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign sid_known = (r_sid < SID_W'(r_total));
    assign table_full = (LIM_W'(r_total) >= LIM_W'(r_max))
                     || (LIM_W'(r_total) >= LIM_W'(TABLE_DEPTH));
    assign walk_last = ((r_idx + CNT_W'(1)) == r_total);

    srgt_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (mem_ctl),
        .i_addr      (mem_addr),
        .i_wr_epoch  (r_req_epoch),
        .i_wr_seq    (mem_wr_seq),
        .o_rd_epoch  (rd_epoch),
        .o_rd_closed (rd_closed),
        .o_rd_seq    (rd_seq)
    );

    srgt_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_eq (cmp_eq),
        .o_le (cmp_le)
    );

    // Route the shared comparator per check step
    always_comb begin
        cmp_a = r_req_seq;
        cmp_b = rd_seq;
        case (r_state)
            S_CHK_DIG: begin
                cmp_a = r_cur_dig;
                cmp_b = '0;
            end
            S_CHK_REQEP: begin
                cmp_a = WORD_W'(r_req_epoch);
                cmp_b = WORD_W'(r_cur_epoch);
            end
            S_CHK_ENTEP: begin
                cmp_a = WORD_W'(rd_epoch);
                cmp_b = WORD_W'(r_cur_epoch);
            end
            S_CHK_BOOT: begin
                cmp_a = r_req_dig;
                cmp_b = r_cur_dig;
            end
            default: begin
                cmp_a = r_req_seq;
                cmp_b = rd_seq;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_max      = r_max;
        n_total    = r_total;
        n_rej      = r_rej;
        n_idx      = r_idx;
        n_ccnt     = r_ccnt;
        n_done     = 1'b0;
        n_status   = r_status;
        n_assigned = r_assigned;
        mem_ctl    = '0;
        mem_addr   = r_sid[IDX_W-1:0];
        mem_wr_seq = '0;

        if (i_cfg_valid) begin
            n_max = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_assigned = '0;
                    n_ccnt     = '0;
                    n_status   = ST_OK;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_cmd)
                    CMD_OPEN: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                        if (!r_creds) begin
                            n_status = ST_UNAUTHORIZED;
                        end else if (table_full) begin
                            n_status = ST_EXHAUSTED;
                        end else begin
                            mem_addr          = r_total[IDX_W-1:0];
                            mem_ctl.epoch_we  = 1'b1;
                            mem_ctl.closed_we = 1'b1;
                            mem_ctl.seq_we    = 1'b1;
                            n_assigned        = ID_W'(r_total);
                            n_total           = r_total + CNT_W'(1);
                        end
                    end
                    CMD_CLOSE: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                        if (!sid_known) begin
                            n_status = ST_NOT_FOUND;
                        end else begin
                            mem_ctl.closed_we    = 1'b1;
                            mem_ctl.closed_wdata = 1'b1;
                        end
                    end
                    CMD_AUTH: begin
                        if (!sid_known) begin
                            if (r_rej != '1) begin
                                n_rej = r_rej + REJ_W'(1);
                            end
                            n_status = ST_UNAUTHORIZED;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            mem_ctl.rd_en = 1'b1;
                            n_state       = S_CHK_DIG;
                        end
                    end
                    CMD_CLOSE_ALL: begin
                        n_idx = '0;
                        if (r_total == '0) begin
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_WALK_RD;
                        end
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_CHK_DIG: begin
                if (rd_closed) begin
                    n_status = ST_CLOSED;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (cmp_eq) begin
                    n_status = ST_UNAUTHORIZED;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_CHK_REQEP;
                end
            end
            S_CHK_REQEP: begin
                if (!cmp_eq) begin
                    n_status = ST_STALE;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_CHK_ENTEP;
                end
            end
            S_CHK_ENTEP: begin
                if (!cmp_eq) begin
                    n_status = ST_STALE;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_CHK_BOOT;
                end
            end
            S_CHK_BOOT: begin
                if (!cmp_eq) begin
                    n_status = ST_STALE;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_CHK_SEQ;
                end
            end
            S_CHK_SEQ: begin
                // Drop replays, advance the watermark otherwise
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (cmp_le) begin
                    if (r_rej != '1) begin
                        n_rej = r_rej + REJ_W'(1);
                    end
                    n_status = ST_REPLAY;
                end else begin
                    mem_ctl.seq_we = 1'b1;
                    mem_wr_seq     = r_req_seq;
                end
            end
            S_WALK_RD: begin
                mem_addr      = r_idx[IDX_W-1:0];
                mem_ctl.rd_en = 1'b1;
                n_state       = S_WALK_WR;
            end
            S_WALK_WR: begin
                mem_addr = r_idx[IDX_W-1:0];
                if (!rd_closed) begin
                    mem_ctl.closed_we    = 1'b1;
                    mem_ctl.closed_wdata = 1'b1;
                    n_ccnt               = r_ccnt + CNT_W'(1);
                end
                if (walk_last) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_WALK_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_max   <= MAX_SESSIONS_RST;
            r_total <= '0;
            r_rej   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_max   <= n_max;
            r_total <= n_total;
            r_rej   <= n_rej;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_ccnt     <= n_ccnt;
        r_status   <= n_status;
        r_assigned <= n_assigned;
        if (accept) begin
            r_cmd       <= i_command;
            r_sid       <= i_session_id;
            r_req_epoch <= i_request_epoch;
            r_creds     <= i_credentials_valid;
            r_cur_epoch <= i_current_epoch;
            r_req_dig   <= i_request_boot_digest;
            r_cur_dig   <= i_current_boot_digest;
            r_req_seq   <= i_request_seq;
        end
    end

    assign o_cfg_ready       = 1'b1;
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_assigned_id     = r_assigned;
    assign o_closed_count    = COUNT_W'(r_ccnt);
    assign o_open_count      = COUNT_W'(r_total);
    assign o_rejection_count = r_rej;

endmodule

`default_nettype wire

@@ rtl/srgt_cmp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srgt_cmp
    import srgt_pkg::*;
(
    input  wire logic [WORD_W-1:0] i_a,
    input  wire logic [WORD_W-1:0] i_b,
    output logic                   o_eq,
    output logic                   o_le
);

    // Shared compare: equality and unsigned a <= b
    assign o_eq = (i_a == i_b);
    assign o_le = (i_a <= i_b);

endmodule

`default_nettype wire

@@ rtl/srgt_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srgt_store
    import srgt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 256,
    parameter int unsigned IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  wire logic               i_clk,
    input  wire t_store_ctl         i_ctl,
    input  wire logic [IDX_W-1:0]   i_addr,
    input  wire logic [EPOCH_W-1:0] i_wr_epoch,
    input  wire logic [WORD_W-1:0]  i_wr_seq,
    output logic [EPOCH_W-1:0]      o_rd_epoch,
    output logic                    o_rd_closed,
    output logic [WORD_W-1:0]       o_rd_seq
);

    logic [EPOCH_W-1:0] r_mem_epoch  [TABLE_DEPTH];
    logic               r_mem_closed [TABLE_DEPTH];
    logic [WORD_W-1:0]  r_mem_seq    [TABLE_DEPTH];

    // Write the entry fields selected by the sequencer
    always_ff @(posedge i_clk) begin
        if (i_ctl.epoch_we) begin
            r_mem_epoch[i_addr] <= i_wr_epoch;
        end
        if (i_ctl.closed_we) begin
            r_mem_closed[i_addr] <= i_ctl.closed_wdata;
        end
        if (i_ctl.seq_we) begin
            r_mem_seq[i_addr] <= i_wr_seq;
        end
    end

    // Registered read; hold the data until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_epoch  <= r_mem_epoch[i_addr];
            o_rd_closed <= r_mem_closed[i_addr];
            o_rd_seq    <= r_mem_seq[i_addr];
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import srgt_pkg::*;

    localparam int unsigned TABLE_DEPTH = 256;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES = 20;

    typedef enum logic [1:0] {
        K_ITEM,
        K_CFG,
        K_DRAIN
    } t_entry_kind;

    // One queued transaction: a command, a register write or a drain point
    typedef struct {
        t_entry_kind              kind;
        logic [1:0]               command;
        logic [SID_W-1:0]         session_id;
        logic [EPOCH_W-1:0]       request_epoch;
        logic                     credentials_valid;
        logic [EPOCH_W-1:0]       now_epoch;
        logic [WORD_W-1:0]        request_digest;
        logic [WORD_W-1:0]        current_digest;
        logic [WORD_W-1:0]        seq_no;
        logic [CFG_W-1:0]         cfg_value;
        int unsigned              gap_pct;
    } t_guard_req;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic [ID_W-1:0]          assigned_id;
        logic [COUNT_W-1:0]       closed_count;
        logic [COUNT_W-1:0]       open_count;
        logic [REJ_W-1:0]         rejection_count;
    } t_guard_verdict;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           i_command = CMD_OPEN;
    logic [SID_W-1:0]     i_session_id = '0;
    logic [EPOCH_W-1:0]   i_request_epoch = '0;
    logic                 i_credentials_valid = 1'b0;
    logic [EPOCH_W-1:0]   i_current_epoch = '0;
    logic [WORD_W-1:0]    i_request_boot_digest = '0;
    logic [WORD_W-1:0]    i_current_boot_digest = '0;
    logic [WORD_W-1:0]    i_request_seq = '0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_done;
    logic [STATUS_W-1:0]  o_status;
    logic [ID_W-1:0]      o_assigned_id;
    logic [COUNT_W-1:0]   o_closed_count;
    logic [COUNT_W-1:0]   o_open_count;
    logic [REJ_W-1:0]     o_rejection_count;

    session_replay_guard_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_command             (i_command),
        .i_session_id          (i_session_id),
        .i_request_epoch       (i_request_epoch),
        .i_credentials_valid   (i_credentials_valid),
        .i_current_epoch       (i_current_epoch),
        .i_request_boot_digest (i_request_boot_digest),
        .i_current_boot_digest (i_current_boot_digest),
        .i_request_seq         (i_request_seq),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_data            (i_cfg_data),
        .o_done                (o_done),
        .o_status              (o_status),
        .o_assigned_id         (o_assigned_id),
        .o_closed_count        (o_closed_count),
        .o_open_count          (o_open_count),
        .o_rejection_count     (o_rejection_count)
    );

    t_guard_req      request_q[$];
    t_guard_verdict  verdict_q[$];
    t_guard_req      on_bus;
    logic [CFG_W-1:0] on_cfg;
    int unsigned     mismatch_count = 0;
    int unsigned     idle_cycles = 0;

    // Table mirror, updated at each accepted transaction
    logic [CFG_W-1:0]   mirror_max = MAX_SESSIONS_RST;
    logic [EPOCH_W-1:0] mirror_epoch [TABLE_DEPTH];
    logic               mirror_closed [TABLE_DEPTH] = '{default: 1'b0};
    logic [WORD_W-1:0]  mirror_seq [TABLE_DEPTH];
    logic [COUNT_W-1:0] mirror_total = '0;
    logic [REJ_W-1:0]   mirror_rejections = '0;

    // Stimulus planning state, used only to shape well-formed requests
    int unsigned        plan_total = 0;
    int unsigned        plan_limit = TABLE_DEPTH;
    logic [EPOCH_W-1:0] plan_epoch [TABLE_DEPTH];
    logic [WORD_W-1:0]  plan_seq [TABLE_DEPTH];
    logic [EPOCH_W-1:0] run_epoch;
    logic [WORD_W-1:0]  run_digest;

    function automatic void bump_rejections();
        if (mirror_rejections != '1) begin
            mirror_rejections = mirror_rejections + 1'b1;
        end
    endfunction

    // Work out the verdict of one command and advance the mirror
    function automatic t_guard_verdict predict_verdict(t_guard_req rq);
        t_guard_verdict v;
        int unsigned    limit;
        logic [7:0]     slot;
        v = '{status: ST_OK, assigned_id: '0, closed_count: '0, open_count: '0,
              rejection_count: '0};
        slot = rq.session_id[7:0];
        case (rq.command)
            CMD_OPEN: begin
                limit = (mirror_max < TABLE_DEPTH) ? mirror_max : TABLE_DEPTH;
                if (!rq.credentials_valid) begin
                    v.status = ST_UNAUTHORIZED;
                end else if (mirror_total >= limit) begin
                    v.status = ST_EXHAUSTED;
                end else begin
                    v.assigned_id = mirror_total[ID_W-1:0];
                    mirror_epoch[mirror_total[7:0]] = rq.request_epoch;
                    mirror_closed[mirror_total[7:0]] = 1'b0;
                    mirror_seq[mirror_total[7:0]] = '0;
                    mirror_total = mirror_total + 1'b1;
                end
            end
            CMD_CLOSE: begin
                if (rq.session_id >= mirror_total) begin
                    v.status = ST_NOT_FOUND;
                end else begin
                    mirror_closed[slot] = 1'b1;
                end
            end
            CMD_AUTH: begin
                if (rq.session_id >= mirror_total) begin
                    bump_rejections();
                    v.status = ST_UNAUTHORIZED;
                end else if (mirror_closed[slot]) begin
                    v.status = ST_CLOSED;
                end else if (rq.current_digest == '0) begin
                    v.status = ST_UNAUTHORIZED;
                end else if (rq.request_epoch != rq.now_epoch
                             || mirror_epoch[slot] != rq.now_epoch) begin
                    v.status = ST_STALE;
                end else if (rq.request_digest != rq.current_digest) begin
                    v.status = ST_STALE;
                end else if (rq.seq_no <= mirror_seq[slot]) begin
                    bump_rejections();
                    v.status = ST_REPLAY;
                end else begin
                    mirror_seq[slot] = rq.seq_no;
                end
            end
            default: begin
                for (int unsigned i = 0; i < mirror_total; i++) begin
                    if (!mirror_closed[i]) begin
                        mirror_closed[i] = 1'b1;
                        v.closed_count = v.closed_count + 1'b1;
                    end
                end
            end
        endcase
        v.open_count = mirror_total;
        v.rejection_count = mirror_rejections;
        return v;
    endfunction

    task automatic add_cmd(input logic [1:0] cmd, input logic [SID_W-1:0] sid,
                           input logic [EPOCH_W-1:0] rep, input logic creds,
                           input logic [EPOCH_W-1:0] cep, input logic [WORD_W-1:0] rdig,
                           input logic [WORD_W-1:0] cdig, input logic [WORD_W-1:0] rseq,
                           input int unsigned gap);
        t_guard_req rq;
        rq = '{kind: K_ITEM, command: cmd, session_id: sid, request_epoch: rep,
               credentials_valid: creds, now_epoch: cep, request_digest: rdig,
               current_digest: cdig, seq_no: rseq, cfg_value: '0, gap_pct: gap};
        request_q = {request_q, rq};
        // track the table loosely so later requests hit live sessions
        if (cmd == CMD_OPEN && creds && plan_total < plan_limit) begin
            plan_epoch[plan_total] = rep;
            plan_seq[plan_total] = '0;
            plan_total++;
        end else if (cmd == CMD_AUTH && sid < plan_total) begin
            if (rseq > plan_seq[sid[7:0]]) begin
                plan_seq[sid[7:0]] = rseq;
            end
        end
    endtask

    task automatic add_cfg(input logic [CFG_W-1:0] value);
        t_guard_req rq;
        rq = '{kind: K_CFG, command: CMD_OPEN, session_id: '0, request_epoch: '0,
               credentials_valid: 1'b0, now_epoch: '0, request_digest: '0,
               current_digest: '0, seq_no: '0, cfg_value: value, gap_pct: 0};
        request_q = {request_q, rq};
        plan_limit = (value < TABLE_DEPTH) ? value : TABLE_DEPTH;
    endtask

    task automatic add_drain();
        t_guard_req rq;
        rq = '{kind: K_DRAIN, command: CMD_OPEN, session_id: '0, request_epoch: '0,
               credentials_valid: 1'b0, now_epoch: '0, request_digest: '0,
               current_digest: '0, seq_no: '0, cfg_value: '0, gap_pct: 0};
        request_q = {request_q, rq};
    endtask

    // Mostly recent sessions, some older ones, a few unknown ids
    function automatic logic [SID_W-1:0] pick_sid();
        int unsigned roll;
        roll = $urandom_range(99);
        if (plan_total == 0 || roll < 5) begin
            return (roll < 2) ? '1 : SID_W'(plan_total + $urandom_range(0, 40));
        end
        if (roll < 20) begin
            return SID_W'($urandom_range(0, plan_total - 1));
        end
        return SID_W'(plan_total - 1
                      - $urandom_range(0, (plan_total > 16) ? 15 : plan_total - 1));
    endfunction

    task automatic add_random(input int unsigned gap);
        int unsigned        roll;
        int unsigned        flavor;
        logic [SID_W-1:0]   sid;
        logic               known;
        logic [EPOCH_W-1:0] rep;
        logic [EPOCH_W-1:0] cep;
        logic [WORD_W-1:0]  rdig;
        logic [WORD_W-1:0]  cdig;
        logic [WORD_W-1:0]  seq;
        roll = $urandom_range(99);
        if (roll < 10) begin
            // noise: every field random
            add_cmd(2'($urandom_range(3)), SID_W'($urandom), $urandom, 1'($urandom),
                    $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, gap);
        end else if (roll < 25) begin
            add_cmd(CMD_OPEN, SID_W'($urandom), ($urandom_range(3) == 0) ? $urandom : run_epoch,
                    $urandom_range(9) != 0, $urandom, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, gap);
        end else if (roll < 31) begin
            add_cmd(CMD_CLOSE, pick_sid(), $urandom, 1'($urandom), $urandom,
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, gap);
        end else if (roll < 32) begin
            add_cmd(CMD_CLOSE_ALL, SID_W'($urandom), $urandom, 1'($urandom), $urandom,
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, gap);
        end else begin
            sid = pick_sid();
            known = sid < plan_total;
            cep = known ? plan_epoch[sid[7:0]] : run_epoch;
            rep = cep;
            seq = known ? plan_seq[sid[7:0]] : '0;
            rdig = run_digest;
            cdig = run_digest;
            flavor = $urandom_range(99);
            if (flavor < 70) begin
                seq = seq + $urandom_range(1, 1000);
            end else if (flavor < 80) begin
                seq = seq - $urandom_range(0, 2);
            end else if (flavor < 85) begin
                cdig = '0;
            end else if (flavor < 92) begin
                // break the request epoch, the current epoch, or both
                case ($urandom_range(2))
                    0: rep = rep ^ (32'd1 << $urandom_range(31));
                    1: cep = cep ^ (32'd1 << $urandom_range(31));
                    default: begin
                        cep = cep ^ (32'd1 << $urandom_range(31));
                        rep = cep;
                    end
                endcase
                seq = seq + 1'b1;
            end else begin
                rdig = rdig ^ (64'd1 << $urandom_range(63));
                seq = seq + 1'b1;
            end
            add_cmd(CMD_AUTH, sid, rep, 1'($urandom), cep, rdig, cdig, seq, gap);
        end
    endtask

    // Clock and reset
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: present queued transactions, predict each one as it is accepted
    always @(posedge i_clk) begin : drive_proc
        logic launch;
        logic post_cfg;
        t_guard_verdict pv;
        launch = 1'b0;
        post_cfg = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                pv = predict_verdict(on_bus);
                verdict_q = {verdict_q, pv};
            end
            if (i_cfg_valid && o_cfg_ready) begin
                mirror_max = on_cfg;
            end
            if ((start && busy) || (i_cfg_valid && !o_cfg_ready)) begin
                // hold the transaction until it is taken
                launch = start;
                post_cfg = i_cfg_valid;
            end else if (request_q.size() != 0) begin
                if (request_q[0].kind == K_ITEM) begin
                    if ($urandom_range(99) >= request_q[0].gap_pct) begin
                        on_bus = request_q.pop_front();
                        launch = 1'b1;
                        i_command <= on_bus.command;
                        i_session_id <= on_bus.session_id;
                        i_request_epoch <= on_bus.request_epoch;
                        i_credentials_valid <= on_bus.credentials_valid;
                        i_current_epoch <= on_bus.now_epoch;
                        i_request_boot_digest <= on_bus.request_digest;
                        i_current_boot_digest <= on_bus.current_digest;
                        i_request_seq <= on_bus.seq_no;
                    end
                end else if (verdict_q.size() == 0 && !o_done) begin
                    // block is idle: write the register or release the drain point
                    if (request_q[0].kind == K_CFG) begin
                        on_cfg = request_q[0].cfg_value;
                        i_cfg_data <= on_cfg;
                        post_cfg = 1'b1;
                    end
                    request_q.delete(0);
                end
            end
        end
        start <= launch;
        i_cfg_valid <= post_cfg;
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Monitor: check each strobed result against the oldest prediction
    always @(posedge i_clk) begin : check_proc
        t_guard_verdict want;
        if (i_rst_n && o_done) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: result with nothing expected, status %0d", $time, o_status);
                mismatch_count++;
            end else begin
                want = verdict_q.pop_front();
                compare_field("status", 32'(want.status), 32'(o_status));
                compare_field("assigned_id", 32'(want.assigned_id), 32'(o_assigned_id));
                compare_field("closed_count", 32'(want.closed_count), 32'(o_closed_count));
                compare_field("open_count", 32'(want.open_count), 32'(o_open_count));
                compare_field("rejection_count", want.rejection_count, o_rejection_count);
            end
        end
    end

    // Watchdog: stop when no transaction moves for too long
    always @(posedge i_clk) begin : watchdog_proc
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus plan and end of run
    initial begin : stimulus_proc
        logic [WORD_W-1:0] dg;
        dg = 64'hDEAD_BEEF_0123_4567;
        run_epoch = $urandom;
        run_digest = {$urandom, $urandom} | 64'd1;

        // directed: check order, extremes and every command
        add_cfg(9'd2);
        add_cmd(CMD_OPEN, '0, 32'd7, 1'b0, '0, dg, dg, '0, 25);
        add_cmd(CMD_CLOSE, '0, '0, 1'b1, '0, dg, dg, '0, 25);
        add_cmd(CMD_AUTH, '0, '0, 1'b1, '0, dg, dg, 64'd1, 25);
        add_cmd(CMD_CLOSE_ALL, '0, '0, 1'b1, '0, '0, '0, '0, 25);
        add_cmd(CMD_OPEN, '0, '0, 1'b1, '0, '0, '0, '0, 25);
        add_cmd(CMD_OPEN, '0, '1, 1'b1, '0, '0, '0, '0, 25);
        add_cmd(CMD_OPEN, '0, 32'd9, 1'b1, '0, '0, '0, '0, 25);
        add_cmd(CMD_AUTH, 16'd0, '0, 1'b1, '0, '0, '0, 64'd1, 25);
        add_cmd(CMD_AUTH, 16'd0, 32'd1, 1'b1, '0, dg, dg, 64'd1, 25);
        add_cmd(CMD_AUTH, 16'd1, '0, 1'b1, '0, dg, dg, 64'd1, 25);
        add_cmd(CMD_AUTH, 16'd0, '0, 1'b1, '0, ~dg, dg, 64'd1, 25);
        add_cmd(CMD_AUTH, 16'd0, '0, 1'b1, '0, dg, dg, '0, 25);
        add_cmd(CMD_AUTH, 16'd0, '0, 1'b1, '0, dg, dg, 64'd5, 25);
        add_cmd(CMD_AUTH, 16'd0, '0, 1'b1, '0, dg, dg, 64'd5, 25);
        add_cmd(CMD_AUTH, 16'd1, '1, 1'b0, '1, '1, '1, '1, 25);
        add_cmd(CMD_CLOSE, 16'd1, '0, 1'b0, '0, '0, '0, '0, 25);
        add_cmd(CMD_CLOSE, 16'd1, '0, 1'b0, '0, '0, '0, '0, 25);
        add_cmd(CMD_AUTH, 16'd1, '1, 1'b1, '1, '1, '1, '1, 25);
        add_cmd(CMD_CLOSE, '1, '1, 1'b1, '1, '1, '1, '1, 25);
        add_cmd(CMD_AUTH, '1, '1, 1'b1, '1, '1, '1, '1, 25);
        add_cmd(CMD_CLOSE_ALL, '1, '1, 1'b1, '1, '1, '1, '1, 25);
        add_cfg(9'd0);
        add_cmd(CMD_OPEN, '0, '0, 1'b1, '0, '0, '0, '0, 25);
        add_cmd(CMD_OPEN, '0, '0, 1'b0, '0, '0, '0, '0, 25);
        add_cfg(9'd256);
        add_cmd(CMD_OPEN, '0, run_epoch, 1'b1, '0, '0, '0, '0, 25);

        // random, sender idling a quarter of the time
        for (int i = 0; i < 450; i++) begin
            if (i % 150 == 149) begin
                add_drain();
            end
            add_random(25);
        end

        // tiny limit: every open refused
        add_cfg(9'd1);
        for (int i = 0; i < 6; i++) begin
            add_cmd(CMD_OPEN, SID_W'($urandom), $urandom, 1'b1, $urandom,
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 49);
        end

        // random, sender idling about half the time
        add_cfg(9'($urandom_range(257, 510)));
        run_digest = {$urandom, $urandom} | 64'd1;
        for (int i = 0; i < 450; i++) begin
            if (i % 150 == 149) begin
                add_drain();
            end
            add_random(49);
        end

        // random, back to back
        add_cfg(9'($urandom_range(plan_total + 40, 255)));
        run_epoch = $urandom;
        for (int i = 0; i < 450; i++) begin
            if (i % 150 == 149) begin
                add_drain();
            end
            add_random(0);
        end

        // fill the table to its depth, then walk it with authorise and close all
        add_cfg(9'd511);
        for (int i = 0; i < 270; i++) begin
            add_cmd(CMD_OPEN, SID_W'($urandom), run_epoch, 1'b1, $urandom,
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    $urandom_range(1) ? 0 : 25);
        end
        for (int i = 0; i < 30; i++) begin
            add_random(10);
        end
        add_cmd(CMD_CLOSE_ALL, '0, '0, 1'b1, '0, '0, '0, '0, 0);
        add_cmd(CMD_CLOSE_ALL, '0, '0, 1'b1, '0, '0, '0, '0, 0);

        // wait for every transaction and result, then let the block settle
        while (request_q.size() != 0 || verdict_q.size() != 0 || start || i_cfg_valid) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/srgt_pkg.sv
rtl/srgt_cmp.sv
rtl/srgt_store.sv
rtl/session_replay_guard_table.sv
tb/sv/tb_top.sv
